[rtl/dksb_pkg.sv]
package dksb_pkg;

  localparam int SECTIONS_DEF    = 8;
  localparam int STACK_DEPTH_DEF = 32;
  localparam int DEST_BITS_DEF   = 8;
  localparam int PACKET_BITS_DEF = 16;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [1:0] {
    REG_WAREHOUSE_ID  = 2'd0,
    REG_SECTION_COUNT = 2'd1,
    REG_DEST_MAP      = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    RES_OK         = 2'd0,
    RES_NO_SECTION = 2'd1,
    RES_FULL       = 2'd2
  } result_code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT
  } fsm_state_t;

  typedef struct packed {
    logic load;
    logic emit_miss;
    logic emit_full;
    logic push;
    logic emit_drained;
    logic pop_read;
    logic emit_pop;
  } ctl_cmd_t;

  typedef struct packed {
    logic hit;
    logic is_drain;
    logic full;
    logic empty;
    logic out_free;
  } ctl_sts_t;

  typedef struct packed {
    logic [7:0]   holder_id;
    logic         last;
    logic         all_empty;
    logic         section_empty;
    result_code_t status;
    logic         packet_valid;
    logic [15:0]  packet_out;
  } result_t;

endpackage

[rtl/dksb_ctrl.sv]
module dksb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dksb_pkg::ctl_sts_t sts,
  output dksb_pkg::ctl_cmd_t cmd
);

  dksb_pkg::fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dksb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dksb_pkg::ST_IDLE: begin
        if (in_valid) state_next = dksb_pkg::ST_EXEC;
      end
      dksb_pkg::ST_EXEC: begin
        priority if (sts.hit && sts.is_drain && !sts.empty) begin
          state_next = dksb_pkg::ST_EMIT;
        end else if (sts.out_free) begin
          state_next = dksb_pkg::ST_IDLE;
        end else begin
          // hold until the output register frees
          state_next = dksb_pkg::ST_EXEC;
        end
      end
      dksb_pkg::ST_EMIT: begin
        if (sts.out_free && sts.empty) state_next = dksb_pkg::ST_IDLE;
      end
      default: state_next = dksb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      dksb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      dksb_pkg::ST_EXEC: begin
        // a non-empty drain starts its first read without waiting for the output
        priority if (sts.hit && sts.is_drain && !sts.empty) begin
          cmd.pop_read = 1'b1;
        end else if (sts.out_free) begin
          priority if (!sts.hit) begin
            cmd.emit_miss = 1'b1;
          end else if (sts.is_drain) begin
            cmd.emit_drained = 1'b1;
          end else if (sts.full) begin
            cmd.emit_full = 1'b1;
          end else begin
            cmd.push = 1'b1;
          end
        end else begin
          cmd = '0;
        end
      end
      dksb_pkg::ST_EMIT: begin
        // emit the fetched entry and fetch the next one in the same cycle
        if (sts.out_free) begin
          cmd.emit_pop = 1'b1;
          cmd.pop_read = !sts.empty;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[rtl/dksb_datapath.sv]
module dksb_datapath #(
  parameter int SECTIONS    = dksb_pkg::SECTIONS_DEF,
  parameter int STACK_DEPTH = dksb_pkg::STACK_DEPTH_DEF,
  parameter int DEST_BITS   = dksb_pkg::DEST_BITS_DEF,
  parameter int PACKET_BITS = dksb_pkg::PACKET_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  dksb_pkg::ctl_cmd_t cmd,
  output dksb_pkg::ctl_sts_t sts,
  input  logic [7:0]         warehouse_id,
  input  logic [3:0]         section_count,
  input  logic [63:0]        dest_map,
  input  logic               in_cmd,
  input  logic [7:0]         in_destination,
  input  logic [15:0]        in_packet_id,
  output dksb_pkg::result_t  res,
  output logic               res_valid,
  input  logic               res_ready
);

  localparam int SEC_W     = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int FILL_W    = $clog2(STACK_DEPTH + 1);
  localparam int MEM_DEPTH = SECTIONS * STACK_DEPTH;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam logic [7:0] DEST_MASK = 8'((1 << DEST_BITS) - 1);

  logic [SEC_W-1:0]       sel;
  logic                   hit;
  logic                   is_drain;
  logic [PACKET_BITS-1:0] pkt;

  logic [FILL_W-1:0] fill      [SECTIONS];
  logic [FILL_W-1:0] fill_next [SECTIONS];
  logic [FILL_W-1:0] fill_sel;

  logic [PACKET_BITS-1:0] mem [MEM_DEPTH];
  logic [PACKET_BITS-1:0] rdata;
  logic [ADDR_W-1:0]      wr_addr;
  logic [ADDR_W-1:0]      rd_addr;

  logic [3:0]       n_use;
  logic             match_hit;
  logic [SEC_W-1:0] match_idx;
  logic             all_empty_cur;
  logic             all_empty_next;
  logic             any_emit;
  logic             out_free;
  dksb_pkg::result_t res_next;

  assign n_use = (section_count > 4'(SECTIONS)) ? 4'(SECTIONS) : section_count;

  // lowest matching entry wins
  always_comb begin
    match_hit = 1'b0;
    match_idx = '0;
    for (int i = SECTIONS - 1; i >= 0; i--) begin
      if ((4'(i) < n_use) && ((dest_map[8*i +: 8] & DEST_MASK) == in_destination)) begin
        match_hit = 1'b1;
        match_idx = SEC_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sel      <= match_idx;
      hit      <= match_hit;
      is_drain <= in_cmd;
      pkt      <= PACKET_BITS'(in_packet_id);
    end
  end

  assign fill_sel = fill[sel];

  always_comb begin
    for (int i = 0; i < SECTIONS; i++) begin
      fill_next[i] = fill[i];
      if (cmd.push && (sel == SEC_W'(i))) fill_next[i] = fill[i] + 1'b1;
      if (cmd.pop_read && (sel == SEC_W'(i))) fill_next[i] = fill[i] - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SECTIONS; i++) fill[i] <= '0;
    end else begin
      for (int i = 0; i < SECTIONS; i++) fill[i] <= fill_next[i];
    end
  end

  always_comb begin
    all_empty_cur  = 1'b1;
    all_empty_next = 1'b1;
    for (int i = 0; i < SECTIONS; i++) begin
      if (4'(i) < n_use) begin
        if (fill[i] != '0) all_empty_cur = 1'b0;
        if (fill_next[i] != '0) all_empty_next = 1'b0;
      end
    end
  end

  assign wr_addr = ADDR_W'(32'(sel) * STACK_DEPTH + 32'(fill_sel));
  assign rd_addr = ADDR_W'(32'(sel) * STACK_DEPTH + 32'(fill_sel) - 1);

  always_ff @(posedge clk) begin
    if (cmd.push) mem[wr_addr] <= pkt;
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_read) rdata <= mem[rd_addr];
  end

  assign any_emit = cmd.emit_miss | cmd.emit_full | cmd.push | cmd.emit_drained | cmd.emit_pop;
  assign out_free = !res_valid || res_ready;

  always_comb begin
    res_next               = '0;
    res_next.status        = dksb_pkg::RES_OK;
    res_next.last          = 1'b1;
    res_next.all_empty     = all_empty_next;
    priority if (cmd.emit_miss) begin
      res_next.status        = dksb_pkg::RES_NO_SECTION;
      res_next.section_empty = 1'b1;
    end else if (cmd.emit_full) begin
      res_next.status = dksb_pkg::RES_FULL;
    end else if (cmd.push) begin
      res_next.holder_id = warehouse_id;
    end else if (cmd.emit_drained) begin
      res_next.section_empty = 1'b1;
    end else begin
      // the fill already counts this entry out; a chained read must not show here
      res_next.packet_out    = 16'(rdata);
      res_next.packet_valid  = 1'b1;
      res_next.section_empty = (fill_sel == '0);
      res_next.last          = (fill_sel == '0);
      res_next.all_empty     = all_empty_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (any_emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (any_emit) res <= res_next;
  end

  assign sts.hit      = hit;
  assign sts.is_drain = is_drain;
  assign sts.full     = (fill_sel == FILL_W'(STACK_DEPTH));
  assign sts.empty    = (fill_sel == '0);
  assign sts.out_free = out_free;

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> fill_sel != FILL_W'(STACK_DEPTH))
    else $error("push into a full section");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_read |-> fill_sel != '0)
    else $error("pop from an empty section");

  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.emit_miss, cmd.emit_full, cmd.push, cmd.emit_drained, cmd.emit_pop}))
    else $error("more than one result in a cycle");

  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    any_emit |-> out_free)
    else $error("result overwrites a beat not yet taken");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> fill_sel == FILL_W'($past(fill_sel) + 1'b1))
    else $error("fill not advanced after push");

endmodule

[rtl/destination_keyed_stack_buffer_core.sv]
// Packet store with one LIFO stack per neighbouring destination.
// Input beats (s_axis_*): tuser selects store (0) or drain (1); tdata carries
// the destination id and the packet id. The destination is looked up in the
// configured map; the lowest matching section in use is addressed.
// Result beats (m_axis_*): a store, an unknown destination, a full section or
// a drain of an empty section gives one beat with tlast high. A drain of a
// section holding N packets gives N beats, newest first, tlast on the final one.
// Timing: one input beat is taken, then the next cycle resolves it; a single
// result is registered once the output register is free. A drain fetches ahead
// by a registered read of the single stack memory, then delivers one packet per
// cycle while the receiver keeps up. One item is handled at a time: no input is
// taken until the last result of the current one is registered. A finished beat
// waits in the output register while the next input is taken; when the receiver
// stalls the controller holds and no packet is lost. Reset clears the state,
// configuration and output valid and empties every stack at once; stack memory
// contents are not cleared. Configuration (APB, 64-bit data, register i at byte
// 8*i): the user must write it only while the block is idle; not enforced.
module destination_keyed_stack_buffer_core #(
  parameter int SECTIONS    = dksb_pkg::SECTIONS_DEF,
  parameter int STACK_DEPTH = dksb_pkg::STACK_DEPTH_DEF,
  parameter int DEST_BITS   = dksb_pkg::DEST_BITS_DEF,
  parameter int PACKET_BITS = dksb_pkg::PACKET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dksb_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [dksb_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [dksb_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [23:0]                     s_axis_tdata,  // destination, packet_id
  input  logic [0:0]                      s_axis_tuser,  // cmd
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // packet_out, section_empty, all_empty, holder_id, zero pad
  output logic [31:0]                     m_axis_tdata,
  output logic [2:0]                      m_axis_tuser,  // packet_valid, status
  output logic                            m_axis_tlast
);

  logic [7:0]  warehouse_id;
  logic [3:0]  section_count;
  logic [63:0] dest_map;
  logic        cfg_wr;
  dksb_pkg::reg_index_t reg_sel;

  dksb_pkg::ctl_cmd_t cmd;
  dksb_pkg::ctl_sts_t sts;
  dksb_pkg::result_t  res;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = dksb_pkg::reg_index_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      warehouse_id  <= '0;
      section_count <= '0;
      dest_map      <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        dksb_pkg::REG_WAREHOUSE_ID:  warehouse_id  <= pwdata[7:0];
        dksb_pkg::REG_SECTION_COUNT: section_count <= pwdata[3:0];
        dksb_pkg::REG_DEST_MAP:      dest_map      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      dksb_pkg::REG_WAREHOUSE_ID:  prdata = 64'(warehouse_id);
      dksb_pkg::REG_SECTION_COUNT: prdata = 64'(section_count);
      dksb_pkg::REG_DEST_MAP:      prdata = dest_map;
      default:                     prdata = '0;
    endcase
  end

  dksb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dksb_datapath #(
    .SECTIONS    (SECTIONS),
    .STACK_DEPTH (STACK_DEPTH),
    .DEST_BITS   (DEST_BITS),
    .PACKET_BITS (PACKET_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .warehouse_id   (warehouse_id),
    .section_count  (section_count),
    .dest_map       (dest_map),
    .in_cmd         (s_axis_tuser[0]),
    .in_destination (s_axis_tdata[7:0]),
    .in_packet_id   (s_axis_tdata[23:8]),
    .res            (res),
    .res_valid      (m_axis_tvalid),
    .res_ready      (m_axis_tready)
  );

  assign m_axis_tdata = {6'b0, res.holder_id, res.all_empty, res.section_empty, res.packet_out};
  assign m_axis_tuser = {res.status, res.packet_valid};
  assign m_axis_tlast = res.last;

endmodule
